// File: design/gcp_pkg.sv
// ----------------------------------------------------------------------------
// gcp_pkg
// Shared types, codes and constants of the gpu command port.
// ----------------------------------------------------------------------------
package gcp_pkg;

   // field and port widths
   localparam int WORD_W      = 32;
   localparam int OP_W        = 2;
   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 11;
   localparam int RSP_DATA_W  = 40;

   // packet store depth, default and legal range 12 to 16
   localparam int PACKET_WORDS_DEF = 12;

   // status word constants
   localparam logic [WORD_W-1:0] STATUS_RESET = 32'h1480_2000;
   localparam logic [WORD_W-1:0] READY_BITS   = 32'h1400_0000;
   localparam logic [WORD_W-1:0] BUSY_BIT     = 32'h0800_0000;
   localparam logic [WORD_W-1:0] DMA_DIR_BITS = 32'h6000_0000;
   localparam logic [WORD_W-1:0] MODE_BITS    = 32'h007F_0000;
   localparam logic [WORD_W-1:0] ENABLE_BIT   = 32'h0080_0000;
   localparam logic [WORD_W-1:0] FIELD_BIT    = 32'h8000_0000;
   localparam logic [WORD_W-1:0] DMA_OFF_WORD = 32'h0400_0000;

   // control command codes (top byte of a control write)
   localparam logic [7:0] CMD_RESET    = 8'h00;
   localparam logic [7:0] CMD_CLEAR_A  = 8'h01;
   localparam logic [7:0] CMD_CLEAR_B  = 8'h02;
   localparam logic [7:0] CMD_DISPLAY  = 8'h03;
   localparam logic [7:0] CMD_DMA      = 8'h04;
   localparam logic [7:0] CMD_MODE     = 8'h08;
   localparam logic [7:0] CMD_INFO     = 8'h10;

   // info query selectors (low half of the control word)
   localparam logic [15:0] INFO_AREA_A   = 16'd0;
   localparam logic [15:0] INFO_AREA_B   = 16'd1;
   localparam logic [15:0] INFO_AREA_C   = 16'd3;
   localparam logic [15:0] INFO_BOUNDS   = 16'd4;
   localparam logic [15:0] INFO_OFFSET_A = 16'd5;
   localparam logic [15:0] INFO_OFFSET_B = 16'd6;
   localparam logic [15:0] INFO_VERSION  = 16'd7;
   localparam logic [WORD_W-1:0] VERSION_WORD = 32'd2;

   typedef enum logic [OP_W-1:0] {
      OP_DATA_WRITE    = 2'd0,
      OP_CONTROL_WRITE = 2'd1,
      OP_STATUS_READ   = 2'd2,
      OP_DATA_READ     = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_PACKET    = 2'd0,
      KIND_STATUS    = 2'd1,
      KIND_READ_DATA = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_LEFT   = 3'd0,
      CSR_AREA_TOP    = 3'd1,
      CSR_AREA_RIGHT  = 3'd2,
      CSR_AREA_BOTTOM = 3'd3,
      CSR_OFFSET_X    = 3'd4,
      CSR_OFFSET_Y    = 3'd5
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;   // apply the request on the input port
      logic step;   // move to the next packet word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic burst;      // request completes a packet
      logic reply;      // request is a read with one reply
      logic last_word;  // response on the output is the final one
   } stat_type;

   // number of words that follow a packet's first word
   function automatic logic [INDEX_W-1:0] extra_words(input logic [7:0] code);
      logic [INDEX_W-1:0] n;
      case (code[7:2])
         6'h08:   n = 4'd3;
         6'h09:   n = 4'd6;
         6'h0A:   n = 4'd4;
         6'h0B:   n = 4'd8;
         6'h0C:   n = 4'd5;
         6'h0D:   n = 4'd8;
         6'h0E:   n = 4'd7;
         6'h0F:   n = 4'd11;
         6'h10:   n = 4'd2;
         6'h12:   n = 4'd3;
         6'h13:   n = 4'd3;
         6'h14:   n = 4'd3;
         6'h16:   n = 4'd4;
         6'h17:   n = 4'd4;
         6'h18:   n = 4'd2;
         6'h19:   n = 4'd3;
         6'h1A:   n = 4'd1;
         6'h1B:   n = 4'd2;
         6'h1C:   n = 4'd1;
         6'h1D:   n = 4'd2;
         6'h1E:   n = 4'd1;
         6'h1F:   n = 4'd2;
         default: n = 4'd0;
      endcase
      case (code)
         8'h02:   n = 4'd2;
         8'h80:   n = 4'd3;
         8'hA0:   n = 4'd2;
         8'hC0:   n = 4'd2;
         default: ;
      endcase
      return n;
   endfunction

endpackage

// File: design/gcp_ctrl.sv
// ----------------------------------------------------------------------------
// gcp_ctrl
// Request/response sequencer: takes one request, then sends its single reply or walks the packet words.
// ----------------------------------------------------------------------------
module gcp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  gcp_pkg::stat_type stat,
   output gcp_pkg::cmd_type  cmd
);
   import gcp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (stat.burst) begin
                  state_in = ST_FETCH;
               end else if (stat.reply) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               state_in = stat.last_word ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_FETCH: ;
         ST_SEND: begin
            rsp_tvalid = 1'b1;
            cmd.step   = rsp_tready & ~stat.last_word;
         end
         default: ;
      endcase
   end

endmodule

// File: design/gcp_datapath.sv
// ----------------------------------------------------------------------------
// gcp_datapath
// Port state, packet framer, packet store and response registers.
// ----------------------------------------------------------------------------
module gcp_datapath #(
   parameter int PACKET_WORDS = gcp_pkg::PACKET_WORDS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [gcp_pkg::OP_W-1:0]         req_tuser,
   input  logic [gcp_pkg::WORD_W-1:0]       req_tdata,
   input  logic                             csr_we,
   input  logic [gcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gcp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  gcp_pkg::cmd_type                 cmd,
   output gcp_pkg::stat_type                stat,
   output logic [gcp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [gcp_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);
   import gcp_pkg::*;

   localparam int ADDR_W = $clog2(PACKET_WORDS);

   // configuration registers
   logic [9:0]  area_left_ff, area_top_ff;
   logic [10:0] area_right_ff, area_bottom_ff, offset_x_ff, offset_y_ff;

   // port state
   logic [WORD_W-1:0]  status_ff, status_in;
   logic [WORD_W-1:0]  info_ff, info_in;
   logic [INDEX_W-1:0] left_ff, left_in;
   logic [INDEX_W-1:0] slot_ff, slot_in;
   logic [1:0]         phase_ff, phase_in;

   // response side
   kind_type           kind_ff, kind_in;
   logic [WORD_W-1:0]  reply_ff, reply_in;
   logic [INDEX_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [WORD_W-1:0]  rd_data_ff;

   logic [WORD_W-1:0]  store [PACKET_WORDS];
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;

   op_type             op;
   logic [10:0]        right_m1, bottom_m1;
   logic [WORD_W-1:0]  value;

   assign op        = op_type'(req_tuser);
   assign right_m1  = area_right_ff - 11'd1;
   assign bottom_m1 = area_bottom_ff - 11'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_left_ff   <= 10'd0;
         area_top_ff    <= 10'd0;
         area_right_ff  <= 11'd256;
         area_bottom_ff <= 11'd240;
         offset_x_ff    <= 11'd0;
         offset_y_ff    <= 11'd0;
      end else if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_AREA_LEFT:   area_left_ff   <= csr_wdata[9:0];
            CSR_AREA_TOP:    area_top_ff    <= csr_wdata[9:0];
            CSR_AREA_RIGHT:  area_right_ff  <= csr_wdata;
            CSR_AREA_BOTTOM: area_bottom_ff <= csr_wdata;
            CSR_OFFSET_X:    offset_x_ff    <= csr_wdata;
            CSR_OFFSET_Y:    offset_y_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next values if the request on the input port is taken
   always_comb begin
      status_in = status_ff;
      info_in   = info_ff;
      left_in   = left_ff;
      slot_in   = slot_ff;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      reply_in  = reply_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      case (op)
         OP_DATA_WRITE: begin
            if (left_ff != '0) begin
               left_in = left_ff - 4'd1;
               wr_en   = (int'(slot_ff) < PACKET_WORDS);
               wr_addr = slot_ff[ADDR_W-1:0];
               slot_in = slot_ff + 4'd1;
            end else begin
               wr_en   = 1'b1;
               left_in = extra_words(req_tdata[31:24]);
               slot_in = 4'd1;
            end
            status_in = status_ff | READY_BITS;
            kind_in   = KIND_PACKET;
         end
         OP_CONTROL_WRITE: begin
            case (req_tdata[31:24])
               CMD_RESET: begin
                  status_in = STATUS_RESET;
                  left_in   = '0;
                  slot_in   = '0;
               end
               CMD_CLEAR_A, CMD_CLEAR_B: begin
                  status_in = status_ff & ~BUSY_BIT;
                  left_in   = '0;
               end
               CMD_DISPLAY: begin
                  status_in = (status_ff & ~ENABLE_BIT) | {8'd0, req_tdata[0], 23'd0};
               end
               CMD_DMA: begin
                  if (req_tdata == DMA_OFF_WORD) begin
                     left_in = '0;
                  end
                  status_in = (status_ff & ~DMA_DIR_BITS) | {1'b0, req_tdata[1:0], 29'd0};
               end
               CMD_MODE: begin
                  status_in = (status_ff & ~MODE_BITS)
                            | {9'd0, req_tdata[5:0], req_tdata[6], 16'd0};
               end
               CMD_INFO: begin
                  case (req_tdata[15:0])
                     INFO_AREA_A, INFO_AREA_B, INFO_AREA_C:
                        info_in = {12'd0, area_top_ff, area_left_ff};
                     INFO_BOUNDS:
                        info_in = {12'd0, bottom_m1[9:0], right_m1[9:0]};
                     INFO_OFFSET_A, INFO_OFFSET_B:
                        info_in = {10'd0, offset_y_ff, offset_x_ff};
                     INFO_VERSION:
                        info_in = VERSION_WORD;
                     default:
                        info_in = '0;
                  endcase
               end
               default: ;
            endcase
         end
         OP_STATUS_READ: begin
            // field bit flips on every third read
            if (phase_ff == 2'd2) begin
               phase_in  = 2'd0;
               status_in = status_ff ^ FIELD_BIT;
            end else begin
               phase_in  = phase_ff + 2'd1;
            end
            reply_in = status_in;
            kind_in  = KIND_STATUS;
         end
         OP_DATA_READ: begin
            status_in = status_ff | READY_BITS;
            reply_in  = info_ff;
            kind_in   = KIND_READ_DATA;
         end
         default: ;
      endcase
      count_in = (int'(slot_in) > PACKET_WORDS) ? INDEX_W'(PACKET_WORDS) : slot_in;
      idx_in   = cmd.take ? '0 : (cmd.step ? idx_ff + 4'd1 : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= STATUS_RESET;
         info_ff   <= '0;
         left_ff   <= '0;
         slot_ff   <= '0;
         phase_ff  <= '0;
         kind_ff   <= KIND_PACKET;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         if (cmd.take) begin
            status_ff <= status_in;
            info_ff   <= info_in;
            left_ff   <= left_in;
            slot_ff   <= slot_in;
            phase_ff  <= phase_in;
            kind_ff   <= kind_in;
            count_ff  <= count_in;
         end
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         reply_ff <= reply_in;
      end
   end

   // packet store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.take && wr_en) begin
         store[wr_addr] <= req_tdata;
      end
      rd_data_ff <= store[idx_ff[ADDR_W-1:0]];
   end

   assign stat.burst     = (op == OP_DATA_WRITE) && (left_in == '0);
   assign stat.reply     = (op == OP_STATUS_READ) || (op == OP_DATA_READ);
   assign stat.last_word = (kind_ff != KIND_PACKET)
                         || (({1'b0, idx_ff} + 5'd1) == {1'b0, count_ff});

   assign value     = (kind_ff == KIND_PACKET) ? rd_data_ff : reply_ff;
   assign rsp_tdata = {4'd0, ((kind_ff == KIND_PACKET) ? idx_ff : 4'd0), value};
   assign rsp_tuser = kind_ff;
   assign rsp_tlast = stat.last_word;

endmodule

// File: design/gpu_command_port_unit.sv
// ----------------------------------------------------------------------------
// gpu_command_port_unit
// Data, control and status port of a graphics processor with packet framer.
// ----------------------------------------------------------------------------
// One request at a time. req_tuser selects data write, control write, status
// read or data read; req_tdata carries the 32-bit word. A control write, or a
// data write that does not finish a packet, gives no response. A status or
// data read gives one response in the next cycle, held until taken. A data
// write that finishes a packet of n words replays the whole packet from the
// store; every word goes through the store's single registered read port,
// with a fetch state before each send state. Status bit 31 toggles on every
// third status read. The drawing area and offset reported by info queries
// come from the csr port and survive the reset command.
// ----------------------------------------------------------------------------
module gpu_command_port_unit #(
   parameter int PACKET_WORDS = gcp_pkg::PACKET_WORDS_DEF  // store depth, 12 to 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gcp_pkg::WORD_W-1:0]      req_tdata,   // [31:0] word
   input  logic [gcp_pkg::OP_W-1:0]        req_tuser,   // [1:0] operation
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gcp_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] value, [35:32] word_index
   output logic [gcp_pkg::KIND_W-1:0]      rsp_tuser,   // [1:0] kind
   output logic                            rsp_tlast,   // last word of packet or reply
   // configuration
   input  logic                            csr_we,
   input  logic [gcp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gcp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: idle / fetch packet word / send response
   gcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // port state, framer, packet store and response registers
   gcp_datapath #(
      .PACKET_WORDS (PACKET_WORDS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// File: design/gcp_checker.sv
// ----------------------------------------------------------------------------
// gcp_checker
// Port-level checks of the gpu command port, bound to the top level.
// ----------------------------------------------------------------------------
module gcp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gcp_pkg::OP_W-1:0]        req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gcp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [gcp_pkg::KIND_W-1:0]      rsp_tuser,
   input logic                            rsp_tlast
);
   import gcp_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // no request is taken while a response is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid)
      else $error("request taken during response");

   // replies are single words with index zero
   a_reply_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_PACKET) |-> rsp_tlast && (rsp_tdata[35:32] == 4'd0))
      else $error("malformed reply");

   // control writes never produce a response
   a_ctrl_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_CONTROL_WRITE) |=> !rsp_tvalid)
      else $error("response after control write");

   // after the final word is taken the port is ready again
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("port not ready after final response");

endmodule

bind gpu_command_port_unit gcp_checker u_gcp_checker (.*);

// File: tb/gpu_command_port_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpu_command_port_unit_test
// Self-checking bench for the gpu command port with packet framer.
// ----------------------------------------------------------------------------
// Requests go in on the req_ stream in bursts with random gaps; responses are
// taken on the rsp_ stream under a changing stall pattern. A predictor inside
// the bench tracks the status word, info latch, framer and packet store, and
// queues the responses each accepted request should give. Every accepted
// response is compared field by field with the oldest queued one. Directed
// tests cover the longest packet, the mode, display, dma, reset and info
// commands, the field toggle on status reads, a framer abort and the bounds
// wrap on zero; random traffic under several csr settings follows.
// ----------------------------------------------------------------------------
module gpu_command_port_unit_test;
   import gcp_pkg::*;

   localparam int PACKET_DEPTH = PACKET_WORDS_DEF;
   localparam int HOLD_CYCLES  = 300;        // long sink hold-off
   localparam int SETTLE       = 8;          // cycles after the last response
   localparam int TIMEOUT_NS   = 2_000_000;  // whole-run limit in nanoseconds

   // one expected response
   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] value;
      logic [3:0]        index;
      logic              last;
   } port_reply_type;

   // dut ports, inputs all known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted port state
   logic [WORD_W-1:0] status_word;
   logic [WORD_W-1:0] info_word;
   logic [3:0]        words_left;
   logic [3:0]        next_slot;
   logic [1:0]        read_phase;
   logic [WORD_W-1:0] frame_words [16];

   // predicted csr contents
   logic [9:0]  cfg_left;
   logic [9:0]  cfg_top;
   logic [10:0] cfg_right;
   logic [10:0] cfg_bottom;
   logic [10:0] cfg_off_x;
   logic [10:0] cfg_off_y;

   port_reply_type pending_replies [$];

   // traffic shaping
   int   burst_left    = 0;
   bit   src_gaps      = 1'b1;
   bit   sink_free     = 1'b1;
   bit   hold_request  = 1'b0;
   int   hold_left     = 0;
   int   pattern_age   = 0;
   logic [7:0] sink_pattern = 8'hFF;

   // bookkeeping
   int error_count    = 0;
   int requests_sent  = 0;
   int replies_seen   = 0;
   int packets_seen   = 0;

   gpu_command_port_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   // words that follow a packet's first word, by its top byte
   function automatic logic [3:0] tail_words(input logic [7:0] head);
      if (head == 8'h02)                       return 4'd2;
      if (head >= 8'h20 && head <= 8'h23)      return 4'd3;
      if (head >= 8'h24 && head <= 8'h27)      return 4'd6;
      if (head >= 8'h28 && head <= 8'h2B)      return 4'd4;
      if (head >= 8'h2C && head <= 8'h2F)      return 4'd8;
      if (head >= 8'h30 && head <= 8'h33)      return 4'd5;
      if (head >= 8'h34 && head <= 8'h37)      return 4'd8;
      if (head >= 8'h38 && head <= 8'h3B)      return 4'd7;
      if (head >= 8'h3C && head <= 8'h3F)      return 4'd11;
      if (head >= 8'h40 && head <= 8'h43)      return 4'd2;
      if (head >= 8'h48 && head <= 8'h53)      return 4'd3;
      if (head >= 8'h58 && head <= 8'h5F)      return 4'd4;
      // 0x60 to 0x7f: groups of four alternating between short lengths
      if (head >= 8'h60 && head <= 8'h63)      return 4'd2;
      if (head >= 8'h64 && head <= 8'h67)      return 4'd3;
      if (head >= 8'h68 && head <= 8'h7F)      return head[2] ? 4'd2 : 4'd1;
      if (head == 8'h80)                       return 4'd3;
      if (head == 8'hA0 || head == 8'hC0)      return 4'd2;
      return 4'd0;
   endfunction

   // word latched by an info query
   function automatic logic [WORD_W-1:0] info_for(input logic [15:0] sel);
      logic [10:0] right_m1;
      logic [10:0] bottom_m1;
      right_m1  = cfg_right - 11'd1;
      bottom_m1 = cfg_bottom - 11'd1;
      case (sel)
         INFO_AREA_A, INFO_AREA_B, INFO_AREA_C:
            return {12'd0, cfg_top, cfg_left};
         // bounds are reported minus one and wrap in ten bits
         INFO_BOUNDS:
            return {12'd0, bottom_m1[9:0], right_m1[9:0]};
         INFO_OFFSET_A, INFO_OFFSET_B:
            return {10'd0, cfg_off_y, cfg_off_x};
         INFO_VERSION:
            return VERSION_WORD;
         default:
            return '0;
      endcase
   endfunction

   task automatic push_reply(input kind_type kind, input logic [WORD_W-1:0] value,
                             input logic [3:0] index, input logic last);
      port_reply_type r;
      r.kind  = kind;
      r.value = value;
      r.index = index;
      r.last  = last;
      pending_replies.push_back(r);
   endtask

   // advance the predicted state by one accepted request
   task automatic predict_request(input op_type op, input logic [WORD_W-1:0] w);
      int i;
      case (op)
         OP_DATA_WRITE: begin
            if (words_left != 4'd0) begin
               words_left = words_left - 4'd1;
               if (next_slot < PACKET_DEPTH) frame_words[next_slot] = w;
               next_slot = next_slot + 4'd1;
            end else begin
               // first word of a new packet
               frame_words[0] = w;
               words_left     = tail_words(w[31:24]);
               next_slot      = 4'd1;
            end
            if (words_left == 4'd0) begin
               for (i = 0; i < next_slot && i < PACKET_DEPTH; i++)
                  push_reply(KIND_PACKET, frame_words[i], 4'(i), (i + 1 == next_slot));
            end
            status_word |= READY_BITS;
         end
         OP_CONTROL_WRITE: begin
            case (w[31:24])
               CMD_RESET: begin
                  status_word = STATUS_RESET;
                  words_left  = 4'd0;
                  next_slot   = 4'd0;
               end
               CMD_CLEAR_A, CMD_CLEAR_B: begin
                  status_word &= ~BUSY_BIT;
                  words_left   = 4'd0;
               end
               CMD_DISPLAY:
                  status_word = (status_word & ~ENABLE_BIT) | (32'(w[0]) << 23);
               CMD_DMA: begin
                  if (w == DMA_OFF_WORD) words_left = 4'd0;
                  status_word = (status_word & ~DMA_DIR_BITS) | (32'(w[1:0]) << 29);
               end
               CMD_MODE:
                  status_word = (status_word & ~MODE_BITS) | (32'(w[5:0]) << 17)
                              | (32'(w[6]) << 16);
               CMD_INFO:
                  info_word = info_for(w[15:0]);
               default: ;
            endcase
         end
         OP_STATUS_READ: begin
            // every third read flips the field bit
            if (read_phase == 2'd2) begin
               read_phase  = 2'd0;
               status_word ^= FIELD_BIT;
            end else begin
               read_phase = read_phase + 2'd1;
            end
            push_reply(KIND_STATUS, status_word, 4'd0, 1'b1);
         end
         default: begin
            status_word |= READY_BITS;
            push_reply(KIND_READ_DATA, info_word, 4'd0, 1'b1);
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // offer one request, wait for the handshake, then predict it
   task automatic send_request(input op_type op, input logic [WORD_W-1:0] w);
      int gap;
      if (burst_left == 0) begin
         gap = src_gaps ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      predict_request(op, w);
      burst_left--;
      requests_sent++;
   endtask

   // stop offering and let every expected response come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write all six csr registers back to back, only while idle
   task automatic load_settings(input logic [9:0] left, input logic [9:0] top,
                                input logic [10:0] right, input logic [10:0] bottom,
                                input logic [10:0] off_x, input logic [10:0] off_y);
      csr_type     order [0:5] = '{CSR_AREA_LEFT, CSR_AREA_TOP, CSR_AREA_RIGHT,
                                   CSR_AREA_BOTTOM, CSR_OFFSET_X, CSR_OFFSET_Y};
      logic [10:0] vals  [0:5];
      int          n;
      vals[0] = {1'b0, left};
      vals[1] = {1'b0, top};
      vals[2] = right;
      vals[3] = bottom;
      vals[4] = off_x;
      vals[5] = off_y;
      for (n = 0; n < 6; n++) begin
         csr_we    <= 1'b1;
         csr_index <= order[n];
         csr_wdata <= vals[n];
         @(posedge clock);
      end
      csr_we     <= 1'b0;
      cfg_left   = left;
      cfg_top    = top;
      cfg_right  = right;
      cfg_bottom = bottom;
      cfg_off_x  = off_x;
      cfg_off_y  = off_y;
   endtask

   // random control word, biased toward the commands that do something
   function automatic logic [WORD_W-1:0] pick_control_word();
      logic [WORD_W-1:0] w;
      logic [7:0]        cmd;
      w = $urandom();
      case ($urandom_range(0, 8))
         0:       cmd = CMD_RESET;
         1:       cmd = CMD_CLEAR_A;
         2:       cmd = CMD_CLEAR_B;
         3:       cmd = CMD_DISPLAY;
         4:       cmd = CMD_DMA;
         5:       cmd = CMD_MODE;
         6, 7:    cmd = CMD_INFO;
         default: cmd = 8'($urandom_range(0, 255));  // mostly unused commands
      endcase
      if (cmd == CMD_INFO && $urandom_range(0, 3) != 0) w[15:0] = 16'($urandom_range(0, 9));
      if (cmd == CMD_DMA && $urandom_range(0, 3) == 0) return DMA_OFF_WORD;
      return {cmd, w[23:0]};
   endfunction

   // head byte of a packet with at least the given number of extra words
   function automatic logic [7:0] pick_packet_head(input int min_tail);
      logic [7:0] head;
      do head = 8'($urandom_range(0, 255)); while (tail_words(head) < min_tail);
      return head;
   endfunction

   // mostly well-formed packets with random payload, plus reads, queries,
   // stray control writes and packets cut short by a framer clear
   task automatic random_traffic(input int count);
      int                sent;
      int                pick;
      int                len;
      int                k;
      logic [7:0]        head;
      logic [WORD_W-1:0] w;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         w    = $urandom();
         if (pick < 58) begin
            head = (pick < 45) ? pick_packet_head(1) : 8'($urandom_range(0, 255));
            len  = tail_words(head);
            send_request(OP_DATA_WRITE, {head, w[23:0]});
            for (k = 0; k < len; k++) send_request(OP_DATA_WRITE, $urandom());
            sent += len + 1;
         end else if (pick < 66) begin
            head = pick_packet_head(2);
            len  = $urandom_range(0, tail_words(head) - 1);
            send_request(OP_DATA_WRITE, {head, w[23:0]});
            for (k = 0; k < len; k++) send_request(OP_DATA_WRITE, $urandom());
            case ($urandom_range(0, 3))
               0:       w = {CMD_RESET, w[23:0]};
               1:       w = {CMD_CLEAR_A, w[23:0]};
               2:       w = {CMD_CLEAR_B, w[23:0]};
               default: w = DMA_OFF_WORD;
            endcase
            send_request(OP_CONTROL_WRITE, w);
            sent += len + 2;
         end else if (pick < 77) begin
            send_request(OP_STATUS_READ, w);
            sent++;
         end else if (pick < 88) begin
            send_request(OP_CONTROL_WRITE, {CMD_INFO, w[23:16], 16'($urandom_range(0, 9))});
            send_request(OP_DATA_READ, $urandom());
            sent += 2;
         end else begin
            send_request(OP_CONTROL_WRITE, pick_control_word());
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   // sink: a long hold-off on request, free running, or a rotating
   // stall pattern that is picked anew at random
   always @(posedge clock) begin : drive_sink
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request || hold_left != 0) begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (sink_free) begin
         rsp_tready <= 1'b1;
      end else begin
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(16, 80);
            case ($urandom_range(0, 3))
               0:       sink_pattern = 8'hFF;
               1:       sink_pattern = 8'h11;   // sparse
               2:       sink_pattern = 8'hEE;   // dense
               default: sink_pattern = 8'($urandom());
            endcase
         end
         pattern_age--;
         sink_pattern = {sink_pattern[6:0], sink_pattern[7]};
         rsp_tready <= sink_pattern[0];
      end
   end

   // compare each accepted response with the oldest expected one
   always @(posedge clock) begin : check_replies
      port_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         if (rsp_tlast && rsp_tuser == KIND_PACKET) packets_seen++;
         if (pending_replies.size() == 0) begin
            $error("unexpected response: kind %0d value %h", rsp_tuser, rsp_tdata[31:0]);
            error_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind mismatch: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[31:0] !== want.value) begin
               $error("value mismatch: expected %h, got %h", want.value, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[35:32] !== want.index) begin
               $error("word_index mismatch: expected %0d, got %0d",
                      want.index, rsp_tdata[35:32]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last mismatch: expected %0b, got %0b", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[39:36] !== 4'd0) begin
               $error("tdata padding mismatch: expected 0, got %h", rsp_tdata[39:36]);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // longest packet, then one-word packets at both ends of the head range
   task automatic test_packet_lengths();
      int k;
      src_gaps  = 1'b0;
      sink_free = 1'b1;
      send_request(OP_DATA_WRITE, 32'h3C00_0000);
      for (k = 0; k < 11; k++) send_request(OP_DATA_WRITE, (k % 2) ? '1 : '0);
      send_request(OP_DATA_WRITE, 32'hFFFF_FFFF);
      send_request(OP_DATA_WRITE, 32'h0000_0000);
      src_gaps = 1'b1;
   endtask

   // status bits from the mode, display, dma and reset commands, field toggle on the third read
   task automatic test_status_controls();
      send_request(OP_CONTROL_WRITE, {CMD_MODE, 24'h00_007F});
      send_request(OP_CONTROL_WRITE, {CMD_DISPLAY, 24'h00_0001});
      send_request(OP_CONTROL_WRITE, {CMD_DMA, 24'h00_0003});
      send_request(OP_STATUS_READ, 32'h0);
      send_request(OP_STATUS_READ, 32'hFFFF_FFFF);
      send_request(OP_STATUS_READ, 32'h0);
      send_request(OP_DATA_READ, 32'h0);
      send_request(OP_CONTROL_WRITE, {CMD_RESET, 24'hFF_FFFF});
      send_request(OP_STATUS_READ, 32'h0);
   endtask

   // an open packet dropped by the exact dma-off word, then a fresh one
   task automatic test_framer_abort();
      send_request(OP_DATA_WRITE, 32'h2C12_3456);
      send_request(OP_DATA_WRITE, 32'hDEAD_BEEF);
      send_request(OP_CONTROL_WRITE, DMA_OFF_WORD);
      send_request(OP_DATA_WRITE, 32'h0211_2233);
      send_request(OP_DATA_WRITE, 32'h4455_6677);
      send_request(OP_DATA_WRITE, 32'h8899_AABB);
   endtask

   // info queries at the register extremes and the zero-bound wrap
   task automatic test_info_queries();
      wait_idle();
      load_settings(10'd1023, 10'd1023, 11'd1024, 11'd1024, 11'd2047, 11'd2047);
      send_request(OP_CONTROL_WRITE, {CMD_INFO, 8'h00, INFO_BOUNDS});
      send_request(OP_DATA_READ, 32'h0);
      send_request(OP_CONTROL_WRITE, {CMD_INFO, 8'hFF, INFO_OFFSET_B});
      send_request(OP_DATA_READ, 32'h0);
      wait_idle();
      load_settings(10'd0, 10'd0, 11'd0, 11'd0, 11'd0, 11'd0);
      send_request(OP_CONTROL_WRITE, {CMD_INFO, 8'h00, INFO_BOUNDS});
      send_request(OP_DATA_READ, 32'h0);
      send_request(OP_CONTROL_WRITE, {CMD_INFO, 8'h00, INFO_VERSION});
      send_request(OP_DATA_READ, 32'h0);
   endtask

   // sink holds off while a long packet and two reads are offered,
   // so the port fills up and stalls its input
   task automatic test_backpressure();
      int k;
      hold_request = 1'b1;
      src_gaps     = 1'b0;
      send_request(OP_DATA_WRITE, 32'h3DAB_CDEF);
      for (k = 0; k < 11; k++) send_request(OP_DATA_WRITE, $urandom());
      send_request(OP_STATUS_READ, 32'h0);
      send_request(OP_DATA_READ, 32'h0);
      src_gaps = 1'b1;
   endtask

   // random traffic under three csr settings
   task automatic test_random_settings();
      wait_idle();
      load_settings(10'd1023, 10'd0, 11'd1, 11'd1024, 11'd2047, 11'd0);
      src_gaps  = 1'b0;
      sink_free = 1'b1;
      random_traffic(20);
      src_gaps  = 1'b1;
      sink_free = 1'b0;
      random_traffic(45);
      wait_idle();
      load_settings(10'd0, 10'd1023, 11'd1024, 11'd1, 11'd0, 11'd2047);
      random_traffic(55);
      wait_idle();
      load_settings(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                    11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                    11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      random_traffic(55);
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      // predictor starts from the reset state
      status_word = STATUS_RESET;
      info_word   = '0;
      words_left  = 4'd0;
      next_slot   = 4'd0;
      read_phase  = 2'd0;
      cfg_left    = 10'd0;
      cfg_top     = 10'd0;
      cfg_right   = 11'd256;
      cfg_bottom  = 11'd240;
      cfg_off_x   = 11'd0;
      cfg_off_y   = 11'd0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_packet_lengths();
      test_status_controls();
      test_framer_abort();
      test_info_queries();
      test_backpressure();
      test_random_settings();
      wait_idle();

      $display("covered %0d requests and %0d responses, %0d of them complete packets",
               requests_sent, replies_seen, packets_seen);
      $display("csr settings: reset, extremes, zero bounds, mixed and random; %0d mismatches",
               error_count);
      if (error_count == 0 && pending_replies.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // hard limit on the whole run
   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d responses still expected", pending_replies.size());
      $display("Verification failed");
      $finish;
   end

endmodule
